### design/pressure_temperature_compensation_core_defines.svh
// Assertion macros shared by the compensation core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/ptc_pkg.sv
// Shared constants, the pipeline context word and arithmetic helpers
// for the compensation core. No dependencies.
package ptc_pkg;

    localparam int DIV_W = 32;

    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_CAL_D = 3'd3;
    localparam logic [2:0] REG_OSS   = 3'd4;

    localparam logic [47:0] CAL_A_RST = 48'd1756636956625;
    localparam logic [47:0] CAL_B_RST = 48'd140623671024241;
    localparam logic [31:0] CAL_C_RST = 32'd405667844;
    localparam logic [31:0] CAL_D_RST = 32'd3724086068;

    localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
    localparam logic signed [31:0] P_C1        = 32'sd3038;
    localparam logic signed [31:0] P_C2        = -32'sd7357;
    localparam logic signed [31:0] P_C3        = 32'sd3791;
    localparam logic [31:0]        B7_SCALE    = 32'd50000;
    localparam logic signed [31:0] B4_BIAS     = 32'sd32768;
    localparam logic [17:0]        PRESS_MAX   = 18'h3FFFF;

    typedef struct packed {
        logic [18:0]        up;
        logic signed [31:0] prod, x1t, b5, b6, m_sq, m_ac2, m_ac3, sq, x2a, x1c;
        logic signed [31:0] m_b2, m_b1, v, x3b, b3, u4, diffu, p, ps, psq, m2, m1;
        logic [31:0]        dvd, dvs, b4, b7;
        logic signed [15:0] temp;
        logic               negq, split, fault;
    } ptc_ctx_t;

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] a);
        return {{16{a[15]}}, a};
    endfunction

endpackage

### design/ptc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on ptc_pkg.
module ptc_div
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             out_valid,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] quo_reg [DIV_W];
    logic [DIV_W-1:0] dvs_reg [DIV_W];
    logic [DIV_W-1:0] vld_reg;
    logic [DIV_W-1:0] rem_next [DIV_W];
    logic [DIV_W-1:0] quo_next [DIV_W];
    logic [DIV_W-1:0] dvs_next [DIV_W];
    logic [DIV_W-1:0] vld_next;

    always_comb
    begin
        logic [DIV_W:0]   sh;
        logic [DIV_W:0]   df;
        logic [DIV_W-1:0] r_in;
        logic [DIV_W-1:0] q_in;
        logic [DIV_W-1:0] d_in;
        logic             v_in;
        for (int i = 0; i < DIV_W; i++)
        begin
            if (i == 0)
            begin
                r_in = '0;
                q_in = dividend;
                d_in = divisor;
                v_in = in_valid;
            end
            else
            begin
                r_in = rem_reg[i-1];
                q_in = quo_reg[i-1];
                d_in = dvs_reg[i-1];
                v_in = vld_reg[i-1];
            end
            sh = {r_in, q_in[DIV_W-1]};
            df = sh - {1'b0, d_in};
            if (!df[DIV_W])
            begin
                rem_next[i] = df[DIV_W-1:0];
                quo_next[i] = {q_in[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = sh[DIV_W-1:0];
                quo_next[i] = {q_in[DIV_W-2:0], 1'b0};
            end
            dvs_next[i] = d_in;
            vld_next[i] = v_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                dvs_reg[i] <= dvs_next[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign quotient  = quo_reg[DIV_W-1];

endmodule

### design/pressure_temperature_compensation_core.sv
// Barometric compensation core: top level, calibration registers and pipeline.
// One input word per cycle is accepted unless the output stalls.
// Depth is set by the two 32-stage dividers plus the multiply stages.
// Whole pipeline stalls while an output word waits; reset clears valid bits
// and loads the calibration defaults. Depends on ptc_pkg and ptc_div.
`include "pressure_temperature_compensation_core_defines.svh"
module pressure_temperature_compensation_core
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temp[15:0], raw_press[34:16], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // temp_tenths[15:0], press_pascal[33:16], zero pad
    output logic [0:0]  m_tuser,   // divide_fault[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg, cal_d_reg;
    logic [1:0]  oss_reg;

    logic [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;

    logic en;
    ptc_ctx_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg, p9_reg, p10_reg;
    ptc_ctx_t p11_reg, p12_reg, p13_reg;
    ptc_ctx_t p1_next, p2_next, p3_next, p4_next, p5_next, p6_next, p7_next, p8_next;
    ptc_ctx_t p9_next, p10_next, p11_next, p12_next, p13_next;
    ptc_ctx_t dly_a_reg [DIV_W];
    ptc_ctx_t dly_b_reg [DIV_W];
    logic [9:0] v_lo_reg;
    logic [2:0] v_hi_reg;
    logic       out_v_reg;
    logic signed [15:0] out_temp_reg, out_temp_next;
    logic [17:0]        out_press_reg, out_press_next;
    logic               out_fault_reg;

    logic        diva_v, divb_v;
    logic [31:0] diva_q, divb_q, divb_dvd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= CAL_A_RST;
            cal_b_reg <= CAL_B_RST;
            cal_c_reg <= CAL_C_RST;
            cal_d_reg <= CAL_D_RST;
            oss_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                REG_CAL_D: cal_d_reg <= cfg_data[31:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    assign ac1 = sx16(cal_a_reg[47:32]);
    assign ac2 = sx16(cal_a_reg[31:16]);
    assign ac3 = sx16(cal_a_reg[15:0]);
    assign ac4 = cal_b_reg[47:32];
    assign ac5 = cal_b_reg[31:16];
    assign ac6 = cal_b_reg[15:0];
    assign b1  = sx16(cal_c_reg[31:16]);
    assign b2  = sx16(cal_c_reg[15:0]);
    assign mc  = sx16(cal_d_reg[31:16]);
    assign md  = sx16(cal_d_reg[15:0]);

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        logic [16:0] d;
        p1_next      = p1_reg;
        d            = {1'b0, s_tdata[15:0]} - {1'b0, ac6};
        p1_next.up   = s_tdata[34:16];
        p1_next.prod = mul_lo({{15{d[16]}}, d}, {16'b0, ac5});
    end

    always_comb
    begin
        logic signed [31:0] x1;
        logic signed [31:0] dv;
        logic [31:0]        num;
        p2_next       = p1_reg;
        x1            = p1_reg.prod >>> 15;
        dv            = x1 + $signed(md);
        num           = mc << 11;
        p2_next.x1t   = x1;
        p2_next.fault = (dv == 32'sd0);
        p2_next.negq  = num[31] ^ dv[31];
        p2_next.dvd   = num[31] ? -num : num;
        p2_next.dvs   = dv[31] ? -dv : dv;
    end

    ptc_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_lo_reg[1]),
        .dividend  (p2_reg.dvd),
        .divisor   (p2_reg.dvs),
        .out_valid (diva_v),
        .quotient  (diva_q)
    );

    always_comb
    begin
        logic signed [31:0] x2;
        logic signed [31:0] b5;
        logic signed [31:0] t;
        p3_next = dly_a_reg[DIV_W-1];
        x2      = p3_next.negq ? -$signed(diva_q) : $signed(diva_q);
        b5      = p3_next.x1t + x2;
        t       = (b5 + 32'sd8) >>> 4;
        if (t > 32'sd32767)
            p3_next.temp = 16'sh7FFF;
        else if (t < -32'sd32768)
            p3_next.temp = -16'sh8000;
        else
            p3_next.temp = t[15:0];
        p3_next.b5 = b5;
        p3_next.b6 = b5 - TEMP_OFFSET;
    end

    always_comb
    begin
        p4_next       = p3_reg;
        p4_next.m_sq  = mul_lo(p3_reg.b6, p3_reg.b6);
        p4_next.m_ac2 = mul_lo(ac2, p3_reg.b6);
        p4_next.m_ac3 = mul_lo(ac3, p3_reg.b6);
    end

    always_comb
    begin
        p5_next     = p4_reg;
        p5_next.sq  = p4_reg.m_sq >>> 12;
        p5_next.x2a = p4_reg.m_ac2 >>> 11;
        p5_next.x1c = p4_reg.m_ac3 >>> 13;
    end

    always_comb
    begin
        p6_next      = p5_reg;
        p6_next.m_b2 = mul_lo(b2, p5_reg.sq);
        p6_next.m_b1 = mul_lo(b1, p5_reg.sq);
    end

    always_comb
    begin
        logic signed [31:0] x3;
        p7_next     = p6_reg;
        x3          = (p6_reg.m_b2 >>> 11) + p6_reg.x2a;
        p7_next.v   = $signed(ac1 << 2) + x3;
        p7_next.x3b = (p6_reg.x1c + (p6_reg.m_b1 >>> 16) + 32'sd2) >>> 2;
    end

    always_comb
    begin
        logic signed [31:0] w;
        p8_next    = p7_reg;
        w          = $signed(p7_reg.v << oss_reg) + 32'sd2;
        p8_next.b3 = w[31] ? ((w + 32'sd3) >>> 2) : (w >>> 2);
        p8_next.u4 = p7_reg.x3b + B4_BIAS;
    end

    always_comb
    begin
        logic [31:0] bp;
        p9_next       = p8_reg;
        bp            = mul_lo({16'b0, ac4}, p8_reg.u4);
        p9_next.b4    = bp >> 15;
        p9_next.diffu = {13'b0, p8_reg.up} - p8_reg.b3;
    end

    always_comb
    begin
        logic [31:0] b7;
        p10_next       = p9_reg;
        b7             = mul_lo(p9_reg.diffu, B7_SCALE >> oss_reg);
        p10_next.b7    = b7;
        p10_next.split = b7[31];
        p10_next.fault = p9_reg.fault || (p9_reg.b4 == 32'd0);
    end

    assign divb_dvd = p10_reg.split ? p10_reg.b7 : {p10_reg.b7[30:0], 1'b0};

    ptc_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_lo_reg[9]),
        .dividend  (divb_dvd),
        .divisor   (p10_reg.b4),
        .out_valid (divb_v),
        .quotient  (divb_q)
    );

    always_comb
    begin
        logic [31:0] pu;
        p11_next    = dly_b_reg[DIV_W-1];
        pu          = p11_next.split ? {divb_q[30:0], 1'b0} : divb_q;
        p11_next.p  = pu;
        p11_next.ps = $signed(pu) >>> 8;
    end

    always_comb
    begin
        p12_next     = p11_reg;
        p12_next.psq = mul_lo(p11_reg.ps, p11_reg.ps);
        p12_next.m2  = mul_lo(P_C2, p11_reg.p);
    end

    always_comb
    begin
        p13_next    = p12_reg;
        p13_next.m1 = mul_lo(p12_reg.psq, P_C1);
    end

    always_comb
    begin
        logic signed [31:0] s;
        logic signed [31:0] pr;
        s  = (p13_reg.m1 >>> 16) + (p13_reg.m2 >>> 16) + P_C3;
        pr = p13_reg.p + (s >>> 4);
        if (p13_reg.fault || pr[31])
            out_press_next = '0;
        else if (pr > $signed({14'b0, PRESS_MAX}))
            out_press_next = PRESS_MAX;
        else
            out_press_next = pr[17:0];
        out_temp_next = p13_reg.fault ? 16'sd0 : p13_reg.temp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_lo_reg  <= '0;
            v_hi_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_lo_reg  <= {v_lo_reg[8:2], diva_v, v_lo_reg[0], s_tvalid};
            v_hi_reg  <= {v_hi_reg[1:0], divb_v};
            out_v_reg <= v_hi_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            p6_reg  <= p6_next;
            p7_reg  <= p7_next;
            p8_reg  <= p8_next;
            p9_reg  <= p9_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            p12_reg <= p12_next;
            p13_reg <= p13_next;
            dly_a_reg[0] <= p2_reg;
            dly_b_reg[0] <= p10_reg;
            for (int i = 1; i < DIV_W; i++)
            begin
                dly_a_reg[i] <= dly_a_reg[i-1];
                dly_b_reg[i] <= dly_b_reg[i-1];
            end
            out_temp_reg  <= out_temp_next;
            out_press_reg <= out_press_next;
            out_fault_reg <= p13_reg.fault;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_press_reg, out_temp_reg};
    assign m_tuser  = out_fault_reg;

    `PTC_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[0], m_tdata[33:0] == 34'd0, "fault word carries non-zero results")
    `PTC_ASSERT_IMP(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `PTC_ASSERT_IMP(a_b4_fault, v_lo_reg[9] && p10_reg.b4 == 32'd0, p10_reg.fault, "zero b4 not flagged")

endmodule
